[hdl/i2cmts_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types, codes and constants shared by the I2C transaction sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    localparam int LEN_WIDTH = 16;

    typedef logic [LEN_WIDTH-1:0] len_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_W_START = 4'd1,
        PH_W_SLA   = 4'd2,
        PH_W_BYTE  = 4'd3,
        PH_R_START = 4'd4,
        PH_R_SLA   = 4'd5,
        PH_R_ACK   = 4'd6,
        PH_R_NACK  = 4'd7
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_RX_ACK  = 3'd3,
        ACT_RX_NACK = 3'd4,
        ACT_STOP    = 3'd5
    } action_t;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    localparam logic [7:0] STATUS_MASK   = 8'hF8;
    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RSTART     = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
    localparam logic [7:0] ST_SLAW_NAK   = 8'h20;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_NAK   = 8'h30;
    localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
    localparam logic [7:0] ST_SLAR_NAK   = 8'h48;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;
    localparam logic [7:0] DIR_READ      = 8'h01;
    localparam logic [7:0] DEV_ADDR_RST  = 8'hA0;

    typedef struct packed {
        logic        command;
        logic [15:0] addr_len;
        logic [15:0] data_len;
        logic [15:0] read_len;
        logic [7:0]  bus_status;
        logic [7:0]  rx_in;
        logic [7:0]  tx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] tx_out;
        logic       rx_valid;
        logic [7:0] rx_out;
        logic       done_res;
        logic [7:0] result_status;
    } rsp_t;

    function automatic len_t mask_len(input logic [15:0] l);
        return l[LEN_WIDTH-1:0];
    endfunction

endpackage

[hdl/i2cmts_input_stage.sv]
// ----------------------------------------------------------------------------
// i2cmts_input_stage
// Request register in front of the sequencer.
// ----------------------------------------------------------------------------
module i2cmts_input_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  i2cmts_pkg::req_t   req,
    output logic               stg_valid,
    input  logic               stg_take,
    output i2cmts_pkg::req_t   stg_req
);
    import i2cmts_pkg::*;

    logic valid_reg;
    req_t data_reg;

    assign req_ready = !valid_reg || stg_take;
    assign stg_valid = valid_reg;
    assign stg_req   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            data_reg <= req;
        end
    end

endmodule

[hdl/i2cmts_sequencer.sv]
// ----------------------------------------------------------------------------
// i2cmts_sequencer
// Transaction state machine, byte counters and response register.
// ----------------------------------------------------------------------------
module i2cmts_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               stg_valid,
    output logic               stg_take,
    input  i2cmts_pkg::req_t   stg_req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output i2cmts_pkg::rsp_t   rsp
);
    import i2cmts_pkg::*;

    logic [7:0] dev_addr_reg;
    phase_t     phase_reg, phase_next;
    len_t       addr_left_reg, addr_left_next;
    len_t       data_left_reg, data_left_next;
    len_t       read_left_reg, read_left_next;
    logic       wrote_reg, wrote_next;
    logic       rsp_valid_reg;
    rsp_t       rsp_reg, rsp_next;

    logic [7:0] s;
    len_t       a_in, d_in, r_in, r_dec;
    logic       a_nz, d_nz, r_nz;

    assign s     = stg_req.bus_status & STATUS_MASK;
    assign a_in  = mask_len(stg_req.addr_len);
    assign d_in  = mask_len(stg_req.data_len);
    assign r_in  = mask_len(stg_req.read_len);
    assign a_nz  = |addr_left_reg;
    assign d_nz  = |data_left_reg;
    assign r_nz  = |read_left_reg;
    assign r_dec = read_left_reg - len_t'(1);

    assign stg_take  = stg_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        addr_left_next = addr_left_reg;
        data_left_next = data_left_reg;
        read_left_next = read_left_reg;
        wrote_next     = wrote_reg;
        if (stg_req.command == CMD_BEGIN)
        begin
            addr_left_next = a_in;
            data_left_next = d_in;
            read_left_next = r_in;
            wrote_next     = (|a_in) || (|d_in);
            if ((|a_in) || (|d_in))
                phase_next = PH_W_START;
            else if (|r_in)
                phase_next = PH_R_START;
            else
                phase_next = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_W_START:
                    phase_next = (s == ST_START) ? PH_W_SLA : PH_IDLE;
                PH_W_SLA, PH_W_BYTE:
                begin
                    if (s == ((phase_reg == PH_W_SLA) ? ST_SLAW_ACK : ST_DATA_ACK))
                    begin
                        if (a_nz)
                        begin
                            addr_left_next = addr_left_reg - len_t'(1);
                            phase_next     = PH_W_BYTE;
                        end
                        else if (d_nz)
                        begin
                            data_left_next = data_left_reg - len_t'(1);
                            phase_next     = PH_W_BYTE;
                        end
                        else if (r_nz)
                            phase_next = PH_R_START;
                        else
                            phase_next = PH_IDLE;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_R_START:
                    phase_next = (s == (wrote_reg ? ST_RSTART : ST_START)) ? PH_R_SLA : PH_IDLE;
                PH_R_SLA, PH_R_ACK:
                begin
                    if (s == ((phase_reg == PH_R_SLA) ? ST_SLAR_ACK : ST_RX_ACK))
                    begin
                        read_left_next = r_dec;
                        phase_next     = (|r_dec) ? PH_R_ACK : PH_R_NACK;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                PH_R_NACK:
                    phase_next = PH_IDLE;
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        rsp_next = '0;
        if (stg_req.command == CMD_BEGIN)
        begin
            if ((|a_in) || (|d_in) || (|r_in))
                rsp_next.bus_action = ACT_START;
            else
                rsp_next.done_res = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_W_START:
                begin
                    if (s == ST_START)
                    begin
                        rsp_next.bus_action = ACT_TX;
                        rsp_next.tx_out     = dev_addr_reg & ~DIR_READ;
                    end
                    else
                    begin
                        rsp_next.done_res      = 1'b1;
                        rsp_next.result_status = s;
                    end
                end
                PH_W_SLA, PH_W_BYTE:
                begin
                    if (s == ((phase_reg == PH_W_SLA) ? ST_SLAW_ACK : ST_DATA_ACK))
                    begin
                        if (a_nz || d_nz)
                        begin
                            rsp_next.bus_action = ACT_TX;
                            rsp_next.tx_out     = stg_req.tx_byte;
                        end
                        else if (r_nz)
                            rsp_next.bus_action = ACT_START;
                        else
                        begin
                            rsp_next.bus_action = ACT_STOP;
                            rsp_next.done_res   = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.done_res      = 1'b1;
                        rsp_next.result_status = s;
                        if (s == ((phase_reg == PH_W_SLA) ? ST_SLAW_NAK : ST_DATA_NAK))
                            rsp_next.bus_action = ACT_STOP;
                    end
                end
                PH_R_START:
                begin
                    if (s == (wrote_reg ? ST_RSTART : ST_START))
                    begin
                        rsp_next.bus_action = ACT_TX;
                        rsp_next.tx_out     = dev_addr_reg | DIR_READ;
                    end
                    else
                    begin
                        rsp_next.done_res      = 1'b1;
                        rsp_next.result_status = s;
                    end
                end
                PH_R_SLA, PH_R_ACK:
                begin
                    if (s == ((phase_reg == PH_R_SLA) ? ST_SLAR_ACK : ST_RX_ACK))
                    begin
                        rsp_next.bus_action = (|r_dec) ? ACT_RX_ACK : ACT_RX_NACK;
                        if (phase_reg == PH_R_ACK)
                        begin
                            rsp_next.rx_valid = 1'b1;
                            rsp_next.rx_out   = stg_req.rx_in;
                        end
                    end
                    else
                    begin
                        rsp_next.done_res      = 1'b1;
                        rsp_next.result_status = s;
                        if (phase_reg == PH_R_SLA && s == ST_SLAR_NAK)
                            rsp_next.bus_action = ACT_STOP;
                    end
                end
                PH_R_NACK:
                begin
                    rsp_next.done_res = 1'b1;
                    if (s == ST_RX_NACK)
                    begin
                        rsp_next.bus_action = ACT_STOP;
                        rsp_next.rx_valid   = 1'b1;
                        rsp_next.rx_out     = stg_req.rx_in;
                    end
                    else
                        rsp_next.result_status = s;
                end
                default:
                    rsp_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= DEV_ADDR_RST;
            phase_reg     <= PH_IDLE;
            addr_left_reg <= '0;
            data_left_reg <= '0;
            read_left_reg <= '0;
            wrote_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                dev_addr_reg <= cfg_wdata;
            if (stg_take)
            begin
                phase_reg     <= phase_next;
                addr_left_reg <= addr_left_next;
                data_left_reg <= data_left_next;
                read_left_reg <= read_left_next;
                wrote_reg     <= wrote_next;
            end
            if (stg_take)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_take)
            rsp_reg <= rsp_next;
    end

endmodule

[hdl/i2c_master_transaction_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Steps a byte-level I2C engine through one transaction: a write, a read, or a write then a read.
//
// Request channel (req_valid/req_ready/req): a begin request loads the
// address, data and read byte counts; each event request reports one
// completed bus event (status, received byte, next byte to send).
// Response channel (rsp_valid/rsp_ready/rsp): exactly one response per
// request with the next bus action, any received byte and the done flag
// with the final status.
// A request passes through the request register, then the state
// machine into the response register. One request per
// cycle is taken while the response side keeps up; the single state
// update per request sets that rate.
// When the receiver stalls the response holds and the request register
// fills, after which req_ready drops until the response is taken.
// Reset empties both registers, returns the state machine to idle with
// zero counters and sets the device address to 0xA0. cfg_we writes the
// device address; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               req_valid,
    output logic               req_ready,
    input  i2cmts_pkg::req_t   req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output i2cmts_pkg::rsp_t   rsp
);
    import i2cmts_pkg::*;

    logic stg_valid;
    logic stg_take;
    req_t stg_req;

    i2cmts_input_stage u_input (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .stg_valid (stg_valid),
        .stg_take  (stg_take),
        .stg_req   (stg_req)
    );

    i2cmts_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stg_valid (stg_valid),
        .stg_take  (stg_take),
        .stg_req   (stg_req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
